// ----- sv/rgb_to_hsv_converter_defines.svh -----
// ----------------------------------------------------------------------------
// RGB to HSV converter assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef RGB_TO_HSV_CONVERTER_DEFINES_SVH
`define RGB_TO_HSV_CONVERTER_DEFINES_SVH

// same-cycle implication
`define RHC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RHC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/rhc_pkg.sv -----
// ----------------------------------------------------------------------------
// RGB to HSV converter package
// Item types, arithmetic constants and width helpers shared by all modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rhc_pkg;

    localparam int HUE_FRAC_BITS_DEF = 6;
    localparam int SAT_FRAC_BITS_DEF = 15;

    // hue stays below 360 degrees: nine integer bits
    localparam int HUE_INT_BITS = 9;
    localparam int NUM_W        = 17;   // 360 * 255 fits in 17 bits
    localparam int HUE_W        = 15;
    localparam int SAT_W        = 16;
    localparam int CH_W         = 8;

    localparam logic [8:0] DEG_0   = 9'd0;
    localparam logic [8:0] DEG_60  = 9'd60;
    localparam logic [8:0] DEG_120 = 9'd120;
    localparam logic [8:0] DEG_240 = 9'd240;
    localparam logic [8:0] DEG_360 = 9'd360;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [SAT_W-1:0] saturation;
        logic [CH_W-1:0]  value;
    } hsv_t;

    // control riding alongside the divider data
    typedef struct packed {
        logic            valid;
        logic            grey;
        logic [CH_W-1:0] value;
    } side_t;

    typedef enum logic [1:0] {
        DOM_RED,
        DOM_GREEN,
        DOM_BLUE
    } dom_t;

    function automatic int max_int(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

endpackage

`default_nettype wire

// ----- sv/rhc_prep.sv -----
// ----------------------------------------------------------------------------
// RGB to HSV front stage
// Finds max, min and dominant channel, forms the hue numerator and
// registers both dividends for the first divider cell.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rhc_prep #(
    parameter int HUE_FRAC_BITS = 6,
    parameter int SAT_FRAC_BITS = 15,
    parameter int QW            = 16
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            adv,
    input  wire logic            pix_valid,
    input  wire rhc_pkg::pixel_t pix,
    output rhc_pkg::side_t       side_reg,
    output logic [7:0]           hrem_reg,
    output logic [QW-1:0]        hq_reg,
    output logic [7:0]           hdiv_reg,
    output logic [7:0]           srem_reg,
    output logic [QW-1:0]        sq_reg,
    output logic [7:0]           sdiv_reg
);
    import rhc_pkg::*;

    localparam int DW = QW + CH_W;

    logic [CH_W-1:0]  mx;
    logic [CH_W-1:0]  mn;
    logic [CH_W-1:0]  chroma;
    dom_t             dom;
    logic [CH_W-1:0]  pa;
    logic [CH_W-1:0]  pb;
    logic [8:0]       base;
    logic [NUM_W-1:0] base_term;
    logic [NUM_W-1:0] diff_term;
    logic [NUM_W-1:0] num;
    logic [DW-1:0]    hd;
    logic [DW-1:0]    sd;

    always_comb
    begin
        mx  = pix.red;
        mn  = pix.red;
        dom = DOM_RED;
        if (pix.green > mx)
        begin
            mx  = pix.green;
            dom = DOM_GREEN;
        end
        if (pix.green < mn)
            mn = pix.green;
        if (pix.blue > mx)
        begin
            mx  = pix.blue;
            dom = DOM_BLUE;
        end
        if (pix.blue < mn)
            mn = pix.blue;
        chroma = mx - mn;
    end

    // pick the channel pair and sector offset of the dominant channel
    always_comb
    begin
        case (dom)
            DOM_RED:
            begin
                pa   = pix.green;
                pb   = pix.blue;
                base = (pix.green >= pix.blue) ? DEG_0 : DEG_360;
            end
            DOM_GREEN:
            begin
                pa   = pix.blue;
                pb   = pix.red;
                base = DEG_120;
            end
            DOM_BLUE:
            begin
                pa   = pix.red;
                pb   = pix.green;
                base = DEG_240;
            end
            default:
            begin
                pa   = '0;
                pb   = '0;
                base = DEG_0;
            end
        endcase
    end

    always_comb
    begin
        base_term = NUM_W'(base) * NUM_W'(chroma);
        if (pa >= pb)
        begin
            diff_term = NUM_W'(DEG_60) * NUM_W'(pa - pb);
            num       = base_term + diff_term;
        end
        else
        begin
            diff_term = NUM_W'(DEG_60) * NUM_W'(pb - pa);
            num       = base_term - diff_term;
        end
        hd = DW'(num) << HUE_FRAC_BITS;
        sd = DW'(chroma) << SAT_FRAC_BITS;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            side_reg <= '0;
        else if (adv)
        begin
            side_reg.valid <= pix_valid;
            side_reg.grey  <= (chroma == '0);
            side_reg.value <= mx;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hrem_reg <= hd[DW-1:QW];
            hq_reg   <= hd[QW-1:0];
            hdiv_reg <= chroma;
            srem_reg <= sd[DW-1:QW];
            sq_reg   <= sd[QW-1:0];
            sdiv_reg <= mx;
        end
    end

endmodule

`default_nettype wire

// ----- sv/rhc_cell.sv -----
// ----------------------------------------------------------------------------
// RGB to HSV divider cell
// One restoring division step for hue and saturation; the dividend shifts
// out of the quotient register as quotient bits shift in.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rhc_cell #(
    parameter int QW = 16
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           adv,
    input  wire rhc_pkg::side_t side_in,
    input  wire logic [7:0]     hrem_in,
    input  wire logic [QW-1:0]  hq_in,
    input  wire logic [7:0]     hdiv_in,
    input  wire logic [7:0]     srem_in,
    input  wire logic [QW-1:0]  sq_in,
    input  wire logic [7:0]     sdiv_in,
    output rhc_pkg::side_t      side_reg,
    output logic [7:0]          hrem_reg,
    output logic [QW-1:0]       hq_reg,
    output logic [7:0]          hdiv_reg,
    output logic [7:0]          srem_reg,
    output logic [QW-1:0]       sq_reg,
    output logic [7:0]          sdiv_reg
);
    import rhc_pkg::*;

    logic [8:0]    ht;
    logic [8:0]    st;
    logic          hge;
    logic          sge;
    logic [7:0]    hrem_next;
    logic [7:0]    srem_next;
    logic [QW-1:0] hq_next;
    logic [QW-1:0] sq_next;

    always_comb
    begin
        ht  = {hrem_in, hq_in[QW-1]};
        st  = {srem_in, sq_in[QW-1]};
        hge = (ht >= {1'b0, hdiv_in});
        sge = (st >= {1'b0, sdiv_in});
        // remainder stays below the divisor, so eight bits hold it
        hrem_next = hge ? 8'(ht - {1'b0, hdiv_in}) : ht[7:0];
        srem_next = sge ? 8'(st - {1'b0, sdiv_in}) : st[7:0];
        hq_next   = {hq_in[QW-2:0], hge};
        sq_next   = {sq_in[QW-2:0], sge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            side_reg <= '0;
        else if (adv)
            side_reg <= side_in;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hrem_reg <= hrem_next;
            hq_reg   <= hq_next;
            hdiv_reg <= hdiv_in;
            srem_reg <= srem_next;
            sq_reg   <= sq_next;
            sdiv_reg <= sdiv_in;
        end
    end

endmodule

`default_nettype wire

// ----- sv/rgb_to_hsv_converter.sv -----
// ----------------------------------------------------------------------------
// RGB to HSV converter
// Converts 8-bit RGB pixels to hue (1/64 degree), saturation (Q1.15) and
// value, one pixel per clock unless stalled, through a chain of division cells.
// ----------------------------------------------------------------------------
// Takes one pixel every clock unless pixel_stall is raised, and returns one
// hsv item per pixel, in order. Each pixel passes one front stage, one divider
// cell per quotient bit and one output register, with QW = max(9 +
// HUE_FRAC_BITS, SAT_FRAC_BITS + 1) quotient bits. The whole chain advances
// together, so a stall while the output register holds an item holds every
// stage and raises pixel_stall in the same cycle.
`timescale 1ns / 1ps
`default_nettype none
`include "rgb_to_hsv_converter_defines.svh"

module rgb_to_hsv_converter #(
    parameter int HUE_FRAC_BITS = rhc_pkg::HUE_FRAC_BITS_DEF,
    parameter int SAT_FRAC_BITS = rhc_pkg::SAT_FRAC_BITS_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            pixel_valid,
    output logic                 pixel_stall,
    input  wire rhc_pkg::pixel_t pixel,
    output logic                 hsv_valid,
    input  wire logic            hsv_stall,
    output rhc_pkg::hsv_t        hsv
);
    import rhc_pkg::*;

    localparam int QW = max_int(HUE_INT_BITS + HUE_FRAC_BITS, SAT_FRAC_BITS + 1);

    side_t         side_c [QW+1];
    logic [7:0]    hrem_c [QW+1];
    logic [QW-1:0] hq_c   [QW+1];
    logic [7:0]    hdiv_c [QW+1];
    logic [7:0]    srem_c [QW+1];
    logic [QW-1:0] sq_c   [QW+1];
    logic [7:0]    sdiv_c [QW+1];

    logic              adv;
    logic              out_valid_reg;
    hsv_t              out_reg;
    hsv_t              out_next;
    logic [QW+HUE_W-1:0] hue_ext;
    logic [QW+SAT_W-1:0] sat_ext;

    // advance the whole chain when the output register is free or draining
    assign adv         = !out_valid_reg || !hsv_stall;
    assign pixel_stall = !adv;

    rhc_prep #(
        .HUE_FRAC_BITS (HUE_FRAC_BITS),
        .SAT_FRAC_BITS (SAT_FRAC_BITS),
        .QW            (QW)
    ) u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .pix_valid (pixel_valid),
        .pix       (pixel),
        .side_reg  (side_c[0]),
        .hrem_reg  (hrem_c[0]),
        .hq_reg    (hq_c[0]),
        .hdiv_reg  (hdiv_c[0]),
        .srem_reg  (srem_c[0]),
        .sq_reg    (sq_c[0]),
        .sdiv_reg  (sdiv_c[0])
    );

    for (genvar i = 0; i < QW; i++)
    begin : g_cell
        rhc_cell #(
            .QW (QW)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .adv      (adv),
            .side_in  (side_c[i]),
            .hrem_in  (hrem_c[i]),
            .hq_in    (hq_c[i]),
            .hdiv_in  (hdiv_c[i]),
            .srem_in  (srem_c[i]),
            .sq_in    (sq_c[i]),
            .sdiv_in  (sdiv_c[i]),
            .side_reg (side_c[i+1]),
            .hrem_reg (hrem_c[i+1]),
            .hq_reg   (hq_c[i+1]),
            .hdiv_reg (hdiv_c[i+1]),
            .srem_reg (srem_c[i+1]),
            .sq_reg   (sq_c[i+1]),
            .sdiv_reg (sdiv_c[i+1])
        );
    end

    // fit quotients to field widths; drop them for grey pixels
    always_comb
    begin
        hue_ext = {{HUE_W{1'b0}}, hq_c[QW]};
        sat_ext = {{SAT_W{1'b0}}, sq_c[QW]};
        out_next.hue        = side_c[QW].grey ? '0 : hue_ext[HUE_W-1:0];
        out_next.saturation = side_c[QW].grey ? '0 : sat_ext[SAT_W-1:0];
        out_next.value      = side_c[QW].value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= side_c[QW].valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            out_reg <= out_next;
    end

    assign hsv_valid = out_valid_reg;
    assign hsv       = out_reg;

    `RHC_ASSERT_NEXT(a_enter_chain, pixel_valid && !pixel_stall, side_c[0].valid,
        "accepted pixel missing from front stage")
    `RHC_ASSERT_NEXT(a_leave_chain, adv && side_c[QW].valid, out_valid_reg,
        "item lost between last cell and output register")
    `RHC_ASSERT_NOW(a_black_grey, side_c[QW].valid && side_c[QW].value == '0,
        side_c[QW].grey, "zero value pixel not flagged grey")

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// RGB to HSV converter testbench
// Sends directed and random pixels through the converter under several
// sender idle and receiver stall mixes. Each hsv item is checked field by
// field against a built-in integer model of the conversion.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    import rhc_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 6;
    localparam int DRAIN_CYCLES  = 40;     // extra wait after the queue empties
    localparam int STUCK_LIMIT   = 2000;   // cycles with no item moving

    logic   clk = 1'b0;
    logic   rst_n = 1'b0;
    logic   pixel_valid;
    logic   pixel_stall;
    pixel_t pixel;
    logic   hsv_valid;
    logic   hsv_stall = 1'b0;
    hsv_t   hsv;

    hsv_t   expected_hsv[$];
    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;
    int     error_count = 0;
    int     pixels_sent = 0;
    int     grey_sent = 0;
    int     results_checked = 0;
    int     stuck_cycles = 0;

    rgb_to_hsv_converter dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel       (pixel),
        .hsv_valid   (hsv_valid),
        .hsv_stall   (hsv_stall),
        .hsv         (hsv)
    );

    always #CLK_HALF clk = ~clk;

    // Integer form of the conversion: hue in 1/64 degree, saturation Q1.15.
    function automatic hsv_t predict_hsv(input pixel_t p);
        hsv_t res;
        dom_t dom;
        int   r, g, b, mx, mn, chroma, num, hue_full, sat_full;
        r = p.red;
        g = p.green;
        b = p.blue;
        mx = r;
        mn = r;
        dom = DOM_RED;
        if (g > mx)
        begin
            mx = g;
            dom = DOM_GREEN;
        end
        if (g < mn) mn = g;
        if (b > mx)
        begin
            mx = b;
            dom = DOM_BLUE;
        end
        if (b < mn) mn = b;
        chroma = mx - mn;
        res = '0;
        res.value = mx[CH_W-1:0];
        if (chroma != 0)
        begin
            case (dom)
                DOM_RED:
                    // wrap negative red-sector hues up by a full turn
                    num = (g >= b) ? int'(DEG_60) * (g - b)
                                   : int'(DEG_360) * chroma - int'(DEG_60) * (b - g);
                DOM_GREEN:
                    num = int'(DEG_120) * chroma + int'(DEG_60) * (b - r);
                default:
                    num = int'(DEG_240) * chroma + int'(DEG_60) * (r - g);
            endcase
            hue_full = (num << HUE_FRAC_BITS_DEF) / chroma;
            sat_full = (chroma << SAT_FRAC_BITS_DEF) / mx;
            res.hue = hue_full[HUE_W-1:0];
            res.saturation = sat_full[SAT_W-1:0];
        end
        return res;
    endfunction

    task automatic send_pixel(input pixel_t p);
        while ($urandom_range(99) < send_idle_pct)
        begin
            pixel_valid <= 1'b0;
            @(posedge clk);
        end
        pixel_valid <= 1'b1;
        pixel <= p;
        @(posedge clk);
        while (pixel_stall) @(posedge clk);
        expected_hsv.push_back(predict_hsv(p));
        pixels_sent++;
        if (p.red == p.green && p.green == p.blue) grey_sent++;
    endtask

    task automatic random_phase(input int count, input int idle_pct, input int stall_pct);
        pixel_t p;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count)
        begin
            p.red = 8'($urandom);
            p.green = 8'($urandom);
            p.blue = 8'($urandom);
            // bias toward ties, greys and rail values
            case ($urandom_range(11))
                0: begin p.green = p.red; p.blue = p.red; end
                1: p.green = p.red;
                2: p.blue = p.green;
                3: p.blue = p.red;
                4: p.red = $urandom_range(1) ? 8'hFF : 8'h00;
                5: p.green = $urandom_range(1) ? 8'hFF : 8'h00;
                6: p.blue = $urandom_range(1) ? 8'hFF : 8'h00;
                7: p.green = p.red + 8'($urandom_range(2)) - 8'd1;
                default: ;
            endcase
            send_pixel(p);
        end
        pixel_valid <= 1'b0;
    endtask

    task automatic test_directed();
        pixel_t cases[$];
        send_idle_pct = 0;
        recv_stall_pct = 0;
        cases = '{
            pixel_t'{8'd0,   8'd0,   8'd0},     // black
            pixel_t'{8'd255, 8'd255, 8'd255},   // white
            pixel_t'{8'd128, 8'd128, 8'd128},   // mid grey
            pixel_t'{8'd255, 8'd0,   8'd0},
            pixel_t'{8'd0,   8'd255, 8'd0},
            pixel_t'{8'd0,   8'd0,   8'd255},
            pixel_t'{8'd255, 8'd255, 8'd0},     // red and green tie
            pixel_t'{8'd0,   8'd255, 8'd255},   // green and blue tie
            pixel_t'{8'd255, 8'd0,   8'd255},   // red and blue tie
            pixel_t'{8'd200, 8'd200, 8'd10},
            pixel_t'{8'd10,  8'd200, 8'd200},
            pixel_t'{8'd200, 8'd10,  8'd200},
            pixel_t'{8'd255, 8'd0,   8'd1},     // hue just under a full turn
            pixel_t'{8'd255, 8'd1,   8'd0},
            pixel_t'{8'd1,   8'd0,   8'd0},     // smallest chroma
            pixel_t'{8'd0,   8'd0,   8'd1},
            pixel_t'{8'd1,   8'd1,   8'd0},
            pixel_t'{8'd255, 8'd254, 8'd254},
            pixel_t'{8'd254, 8'd255, 8'd0},
            pixel_t'{8'd0,   8'd1,   8'd255},
            pixel_t'{8'd128, 8'd64,  8'd32},
            pixel_t'{8'd32,  8'd128, 8'd64},
            pixel_t'{8'd64,  8'd32,  8'd128},
            pixel_t'{8'd170, 8'd85,  8'd0}
        };
        foreach (cases[i]) send_pixel(cases[i]);
        pixel_valid <= 1'b0;
    endtask

    task automatic test_no_idle();
        random_phase(420, 0, 0);
    endtask

    task automatic test_sender_idle();
        random_phase(410, 73, 0);
    endtask

    task automatic test_receiver_stall();
        random_phase(410, 0, 73);
    endtask

    task automatic test_both_idle();
        random_phase(410, 29, 29);
    endtask

    always @(posedge clk)
        hsv_stall <= ($urandom_range(99) < recv_stall_pct);

    // Compare every accepted hsv item with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && hsv_valid && !hsv_stall)
        begin
            if (expected_hsv.size() == 0)
            begin
                $error("unexpected hsv item: hue %0d saturation %0d value %0d",
                       hsv.hue, hsv.saturation, hsv.value);
                error_count++;
            end
            else
            begin
                hsv_t want;
                want = expected_hsv.pop_front();
                results_checked++;
                if (hsv.hue !== want.hue)
                begin
                    $error("hue: expected %0d, got %0d", want.hue, hsv.hue);
                    error_count++;
                end
                if (hsv.saturation !== want.saturation)
                begin
                    $error("saturation: expected %0d, got %0d",
                           want.saturation, hsv.saturation);
                    error_count++;
                end
                if (hsv.value !== want.value)
                begin
                    $error("value: expected %0d, got %0d", want.value, hsv.value);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (pixel_valid && !pixel_stall) || (hsv_valid && !hsv_stall))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("timeout: nothing moved for %0d cycles, %0d items pending",
                     STUCK_LIMIT, expected_hsv.size());
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        pixel_valid <= 1'b0;
        pixel <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_no_idle();
        test_sender_idle();
        test_receiver_stall();
        test_both_idle();

        while (expected_hsv.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_hsv.size() != 0)
        begin
            $error("%0d hsv items never arrived", expected_hsv.size());
            error_count++;
        end

        $display("Converted %0d pixels (%0d grey) and checked %0d hsv items,",
                 pixels_sent, grey_sent, results_checked);
        $display("with free-running, sender-idle, receiver-stall and mixed traffic.");
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
